// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// File: rtl/core/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Codes and types shared by the sentence framer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

  localparam logic [1:0] OP_POLL = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] START_MARKER_RST = 8'h24;
  localparam logic [7:0] END_MARKER_RST   = 8'h0a;

  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  typedef enum logic [1:0] {
    PH_WAITING = 2'd0,
    PH_READING = 2'd1,
    PH_READY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_RESULT = 2'd2
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/nsf_ram.sv
// ----------------------------------------------------------------------------
// nsf_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/nmea_sentence_framer_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core
// Frames a GPS byte stream into sentence buffers held in one RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid / in_ready    | operation, rx_byte, read_sentence,
//           |                        | read_position
//  out      | out_valid / out_ready  | accepted, read_char, phase,
//           |                        | current_sentence
//  cfg      | APB psel/penable       | start_marker (0x0), end_marker (0x4)
//
//  A request is first accepted (RAM write or read address), then its result is loaded.
//  A poll in the ready phase sweeps the RAM, one entry a cycle, clearing all
//  SENTENCES*SENTENCE_LEN entries before its result, with in_ready low meanwhile.
//  After reset the same sweep runs (512 entries by default) before in_ready rises.
//  A stalled output register holds the engine in the result state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_framer_core
  import nsf_pkg::*;
#(
  parameter int SENTENCES    = 4,
  parameter int SENTENCE_LEN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [1:0]  read_sentence,
  input  wire logic [6:0]  read_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic [7:0]       read_char,
  output logic [1:0]       phase,
  output logic [1:0]       current_sentence
);

  localparam int DEPTH  = SENTENCES * SENTENCE_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIDX_W = (SENTENCES > 1) ? $clog2(SENTENCES) : 1;
  localparam int CIDX_W = $clog2(SENTENCE_LEN);

  logic [7:0] start_marker;
  logic [7:0] end_marker;

  state_t state, state_next;
  phase_t phase_q, phase_q_next;
  logic [SIDX_W-1:0] sent_idx, sent_idx_next;
  logic [CIDX_W-1:0] char_idx, char_idx_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic              clr_emit, clr_emit_next;

  logic [1:0] req_op, req_op_next;
  logic       req_acc, req_acc_next;
  logic       req_inrange, req_inrange_next;
  logic [1:0] req_rs, req_rs_next;
  logic [6:0] req_rp, req_rp_next;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic [31:0] rd_lin_in;
  logic [31:0] rd_lin_req;
  logic [31:0] wr_lin;
  logic        rd_inrange;
  logic        in_fire;
  logic        out_load;
  logic [SIDX_W+1:0] sidx_ext;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_START_MARKER: start_marker <= pwdata[7:0];
        REG_END_MARKER:   end_marker   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START_MARKER: prdata = {24'd0, start_marker};
      REG_END_MARKER:   prdata = {24'd0, end_marker};
      default:          prdata = 32'd0;
    endcase
  end

  // Address arithmetic
  assign rd_lin_in  = 32'(read_sentence) * 32'(SENTENCE_LEN) + 32'(read_position);
  assign rd_lin_req = 32'(req_rs) * 32'(SENTENCE_LEN) + 32'(req_rp);
  assign wr_lin     = 32'(sent_idx) * 32'(SENTENCE_LEN) + 32'(char_idx);
  assign rd_inrange = (32'(read_sentence) < 32'(SENTENCES)) &&
                      (32'(read_position) < 32'(SENTENCE_LEN));

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == ST_RESULT) && (!out_valid || out_ready);
  assign sidx_ext = (SIDX_W + 2)'(sent_idx);

  nsf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      phase_q  <= PH_WAITING;
      sent_idx <= '0;
      char_idx <= '0;
      clr_cnt  <= '0;
      clr_emit <= 1'b0;
    end else begin
      state    <= state_next;
      phase_q  <= phase_q_next;
      sent_idx <= sent_idx_next;
      char_idx <= char_idx_next;
      clr_cnt  <= clr_cnt_next;
      clr_emit <= clr_emit_next;
    end
  end

  always_ff @(posedge clk) begin
    req_op      <= req_op_next;
    req_acc     <= req_acc_next;
    req_inrange <= req_inrange_next;
    req_rs      <= req_rs_next;
    req_rp      <= req_rp_next;
  end

  always_comb begin
    state_next       = state;
    phase_q_next     = phase_q;
    sent_idx_next    = sent_idx;
    char_idx_next    = char_idx;
    clr_cnt_next     = clr_cnt;
    clr_emit_next    = clr_emit;
    req_op_next      = req_op;
    req_acc_next     = req_acc;
    req_inrange_next = req_inrange;
    req_rs_next      = req_rs;
    req_rp_next      = req_rp;
    ram_we           = 1'b0;
    ram_wdata        = rx_byte;
    ram_addr         = rd_lin_req[ADDR_W-1:0];

    unique case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_wdata    = 8'd0;
        ram_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
          clr_cnt_next  = '0;
          clr_emit_next = 1'b0;
          state_next    = clr_emit ? ST_RESULT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = rd_lin_in[ADDR_W-1:0];
        if (in_fire) begin
          req_op_next      = operation;
          req_acc_next     = 1'b0;
          req_inrange_next = rd_inrange;
          req_rs_next      = read_sentence;
          req_rp_next      = read_position;
          state_next       = ST_RESULT;
          unique case (operation)
            OP_POLL: begin
              if (phase_q == PH_READY) begin
                phase_q_next  = PH_WAITING;
                clr_emit_next = 1'b1;
                state_next    = ST_CLEAR;
              end
            end
            OP_BYTE: begin
              if (phase_q != PH_READY) begin
                req_acc_next = 1'b1;
              end
              if (phase_q == PH_WAITING) begin
                if (rx_byte == start_marker) begin
                  phase_q_next  = PH_READING;
                  sent_idx_next = '0;
                  char_idx_next = '0;
                end
              end else if (phase_q == PH_READING) begin
                ram_we   = 1'b1;
                ram_addr = wr_lin[ADDR_W-1:0];
                if (rx_byte == end_marker) begin
                  ram_wdata    = 8'd0;
                  phase_q_next = PH_READY;
                end else if (rx_byte == start_marker) begin
                  ram_wdata     = 8'd0;
                  char_idx_next = '0;
                  if (sent_idx != SIDX_W'(SENTENCES - 1)) begin
                    sent_idx_next = sent_idx + 1'b1;
                  end
                end else if (char_idx != CIDX_W'(SENTENCE_LEN - 1)) begin
                  char_idx_next = char_idx + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted         <= req_acc;
      read_char        <= (req_op == OP_READ && req_inrange) ? ram_rdata : 8'd0;
      phase            <= phase_q;
      current_sentence <= sidx_ext[1:0];
    end
  end

  `ASSERT_NEVER(a_no_accept_in_clear, clk, rst, (state == ST_CLEAR) && in_valid && in_ready, "request accepted during clear sweep")
  `ASSERT_PROP(a_poll_starts_clear, clk, rst, (in_fire && operation == OP_POLL && phase_q == PH_READY) |=> (state == ST_CLEAR && phase_q == PH_WAITING), "poll in ready phase did not start clear")
  `ASSERT_PROP(a_refused_byte_holds, clk, rst, (in_fire && operation == OP_BYTE && phase_q == PH_READY) |=> (phase_q == PH_READY && $stable(sent_idx) && !req_acc), "refused byte changed state")

endmodule

`default_nettype wire

// File: bench/nsf_bench_pkg.sv
// ----------------------------------------------------------------------------
// nsf_bench_pkg
// Scoreboard for the sentence framer: keeps its own copy of the sentence
// store, phase, indexes and markers, predicts one reply per accepted request
// and compares each reply from the block against the oldest prediction.
// ----------------------------------------------------------------------------
package nsf_bench_pkg;
  import nsf_pkg::*;

  localparam int NUM_SENTENCES  = 4;
  localparam int SENTENCE_CELLS = 128;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_char;
    phase_t     phase;
    logic [1:0] sentence;
  } framer_reply_t;

  class framer_scoreboard;
    logic [7:0]    cells [NUM_SENTENCES][SENTENCE_CELLS];
    phase_t        framer_phase;
    int unsigned   sentence_idx;
    int unsigned   char_idx;
    logic [7:0]    start_mark;
    logic [7:0]    end_mark;
    framer_reply_t predicted_replies[$];
    int unsigned   mismatches;

    function new();
      clear_cells();
      framer_phase = PH_WAITING;
      sentence_idx = 0;
      char_idx     = 0;
      start_mark   = START_MARKER_RST;
      end_mark     = END_MARKER_RST;
      mismatches   = 0;
    endfunction

    function void clear_cells();
      foreach (cells[s, c]) cells[s][c] = 8'h00;
    endfunction

    function void set_register(logic reg_idx, logic [7:0] value);
      if (reg_idx == REG_START_MARKER) start_mark = value;
      else end_mark = value;
    endfunction

    function int unsigned pending();
      return predicted_replies.size();
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] rx, logic [1:0] rs,
                               logic [6:0] rp);
      framer_reply_t r;
      r = '0;
      case (op)
        OP_POLL: begin
          if (framer_phase == PH_READY) begin
            clear_cells();
            framer_phase = PH_WAITING;
          end
        end
        OP_BYTE: begin
          if (framer_phase != PH_READY) begin
            r.accepted = 1'b1;
            if (framer_phase == PH_WAITING) begin
              if (rx == start_mark) begin
                framer_phase = PH_READING;
                sentence_idx = 0;
                char_idx     = 0;
              end
            end else if (rx == end_mark) begin
              cells[sentence_idx][char_idx] = 8'h00;
              framer_phase = PH_READY;
            end else if (rx == start_mark) begin
              cells[sentence_idx][char_idx] = 8'h00;
              char_idx = 0;
              if (sentence_idx < NUM_SENTENCES - 1) sentence_idx++;
            end else begin
              cells[sentence_idx][char_idx] = rx;
              if (char_idx < SENTENCE_CELLS - 1) char_idx++;
            end
          end
        end
        OP_READ: begin
          if (rs < NUM_SENTENCES && rp < SENTENCE_CELLS) r.read_char = cells[rs][rp];
        end
        default: begin
        end
      endcase
      r.phase    = framer_phase;
      r.sentence = sentence_idx[1:0];
      predicted_replies.push_back(r);
    endfunction

    function void check_result(framer_reply_t got);
      framer_reply_t want;
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: accepted=%0d char=%02h phase=%0d sentence=%0d",
                   got.accepted, got.read_char, got.phase, got.sentence);
        return;
      end
      want = predicted_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("reply mismatch: expected accepted=%0d char=%02h phase=%0d sentence=%0d,",
                   want.accepted, want.read_char, want.phase, want.sentence,
                   " got accepted=%0d char=%02h phase=%0d sentence=%0d",
                   got.accepted, got.read_char, got.phase, got.sentence);
      end
    endfunction
  endclass

endpackage

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives nmea_sentence_framer_core with directed and random request streams
// over several marker settings, with random stalls on both channels (except in the
// last, quiet run), and checks every reply against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nsf_pkg::*;
  import nsf_bench_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int TIMEOUT_CYCLES  = 3_000_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 1200;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [7:0]  rx_byte;
  logic [1:0]  read_sentence;
  logic [6:0]  read_position;
  logic        out_valid;
  logic        out_ready;
  logic        accepted;
  logic [7:0]  read_char;
  logic [1:0]  phase;
  logic [1:0]  current_sentence;

  bit          quiet;
  bit          hold_off_req;
  int unsigned items_sent;

  framer_scoreboard sb = new();

  nmea_sentence_framer_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .rx_byte          (rx_byte),
    .read_sentence    (read_sentence),
    .read_position    (read_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .accepted         (accepted),
    .read_char        (read_char),
    .phase            (phase),
    .current_sentence (current_sentence)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic send_request(input logic [1:0] op, input logic [7:0] rx,
                              input logic [1:0] rs, input logic [6:0] rp);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    rx_byte       <= rx;
    read_sentence <= rs;
    read_position <= rp;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, rx, rs, rp);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_request(OP_BYTE, rx, 2'($urandom), 7'($urandom));
  endtask

  task automatic send_read(input logic [1:0] rs, input logic [6:0] rp);
    send_request(OP_READ, 8'($urandom), rs, rp);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(reg_idx, value);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned n_sent;
    int unsigned len;
    logic [7:0]  rx;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        send_request(OP_POLL, 8'($urandom), 2'($urandom), 7'($urandom));
        send_byte(sb.start_mark);
        n_sent = $urandom_range(1, 6);
        for (int s = 0; s < n_sent; s++) begin
          if (s > 0) send_byte(sb.start_mark);
          len = ($urandom_range(0, 14) == 0) ? $urandom_range(120, 135)
                                             : $urandom_range(0, 20);
          repeat (len) begin
            do rx = 8'($urandom); while (rx == sb.start_mark || rx == sb.end_mark);
            send_byte(rx);
          end
        end
        send_byte(sb.end_mark);
        repeat ($urandom_range(3, 10))
          send_read(2'($urandom), ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                               : 7'($urandom_range(0, 24)));
        if ($urandom_range(0, 2) == 0) send_byte(8'($urandom));
        send_request(OP_POLL, 8'($urandom), 2'($urandom), 7'($urandom));
      end else begin
        repeat ($urandom_range(3, 12)) begin
          case ($urandom_range(0, 7))
            0, 1:    rx = sb.start_mark;
            2:       rx = sb.end_mark;
            default: rx = 8'($urandom);
          endcase
          send_request(2'($urandom), rx, 2'($urandom), 7'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_POLL;
    rx_byte       = 8'h00;
    read_sentence = 2'd0;
    read_position = 7'd0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    write_register(REG_START_MARKER, START_MARKER_RST);
    write_register(REG_END_MARKER, END_MARKER_RST);

    send_request(OP_NONE, 8'hff, 2'd3, 7'd127);
    send_request(OP_POLL, 8'h00, 2'd0, 7'd0);
    send_read(2'd0, 7'd0);
    send_byte("A");
    send_byte(END_MARKER_RST);
    send_byte(START_MARKER_RST);
    send_byte("G");
    send_byte("P");
    send_byte(8'h0d);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(START_MARKER_RST);
    send_byte(START_MARKER_RST);
    send_byte("X");
    send_byte(END_MARKER_RST);
    send_byte("Z");
    send_byte(START_MARKER_RST);
    send_request(OP_NONE, 8'h00, 2'd0, 7'd0);
    send_read(2'd0, 7'd0);
    send_read(2'd0, 7'd4);
    send_read(2'd0, 7'd5);
    send_read(2'd2, 7'd0);
    send_read(2'd3, 7'd127);
    send_request(OP_POLL, 8'hff, 2'd3, 7'd127);
    send_read(2'd0, 7'd0);
    settle();

    hold_off_req = 1'b1;
    run_random(items_sent + RANDOM_ITEMS / 4);
    settle();

    write_register(REG_START_MARKER, 8'h7e);
    write_register(REG_END_MARKER, 8'h7e);
    run_random(items_sent + RANDOM_ITEMS / 4);
    settle();

    write_register(REG_START_MARKER, 8'h00);
    write_register(REG_END_MARKER, 8'hff);
    run_random(items_sent + RANDOM_ITEMS / 4);
    settle();

    quiet = 1'b1;
    write_register(REG_START_MARKER, 8'hff);
    write_register(REG_END_MARKER, 8'h00);
    run_random(items_sent + RANDOM_ITEMS / 4);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("nmea_sentence_framer_core regression: pass");
    else
      $display("nmea_sentence_framer_core regression: fail");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if (quiet) @(posedge clk);
        else repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    framer_reply_t got;
    if (!rst && out_valid && out_ready) begin
      got.accepted  = accepted;
      got.read_char = read_char;
      got.phase     = phase_t'(phase);
      got.sentence  = current_sentence;
      sb.check_result(got);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("nmea_sentence_framer_core regression: fail");
    $finish;
  end

endmodule
